@@ design/hgcd_pkg.sv @@
package hgcd_pkg;

    // angle format of the input coordinates
    localparam int ANGLE_FRAC_BITS  = 20;
    localparam int CORDIC_STEPS_DEF = 24;

    // signed datapath word for cordic and q30 values
    localparam int Q_W = 36;
    typedef logic signed [Q_W-1:0] t_q;

    // degree-to-radian product width
    localparam int P_W = 57;
    typedef logic signed [P_W-1:0] t_prod;

    // square root radicand width and step count
    localparam int SQ_W     = 62;
    localparam int SQ_STEPS = 31;
    typedef logic [SQ_W-1:0] t_sq;

    // q30 constants and the q32 degree-to-radian factor
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;
    localparam logic signed [27:0] DEG2RAD_Q32 = 28'sd74961321;
    localparam t_q CORDIC_GAIN_INV = t_q'(652032874);

    // degree constants in input scaling
    localparam logic signed [30:0] DEG360 = 31'(360 << ANGLE_FRAC_BITS);
    localparam logic signed [30:0] DEG180 = 31'(180 << ANGLE_FRAC_BITS);
    localparam logic signed [30:0] DEG90  = 31'(90 << ANGLE_FRAC_BITS);

    // rounding shifts for full and half angles
    localparam int SH_FULL = ANGLE_FRAC_BITS + 2;
    localparam int SH_HALF = ANGLE_FRAC_BITS + 3;

    // output saturation limit
    localparam int DIST_W = 26;

    // arctangent of 2^-k in q30
    function automatic t_q atan_q30(input int k);
        t_q v;
        case (k)
            0:  v = t_q'(32'h3243F6A8);
            1:  v = t_q'(32'h1DAC6705);
            2:  v = t_q'(32'h0FADBAFC);
            3:  v = t_q'(32'h07F56EA6);
            4:  v = t_q'(32'h03FEAB76);
            5:  v = t_q'(32'h01FFD55B);
            6:  v = t_q'(32'h00FFFAAA);
            7:  v = t_q'(32'h007FFF55);
            8:  v = t_q'(32'h003FFFEA);
            9:  v = t_q'(32'h001FFFFD);
            10: v = t_q'(32'h000FFFFF);
            11: v = t_q'(32'h0007FFFF);
            12: v = t_q'(32'h0003FFFF);
            13: v = t_q'(32'h0001FFFF);
            14: v = t_q'(32'h0000FFFF);
            15: v = t_q'(32'h00007FFF);
            16: v = t_q'(32'h00003FFF);
            17: v = t_q'(32'h00001FFF);
            18: v = t_q'(32'h00000FFF);
            19: v = t_q'(32'h000007FF);
            20: v = t_q'(32'h000003FF);
            21: v = t_q'(32'h000001FF);
            22: v = t_q'(32'h000000FF);
            23: v = t_q'(32'h0000007F);
            24: v = t_q'(32'h0000003F);
            25: v = t_q'(32'h0000001F);
            26: v = t_q'(32'h0000000F);
            27: v = t_q'(32'h00000008);
            28: v = t_q'(32'h00000004);
            29: v = t_q'(32'h00000002);
            30: v = t_q'(32'h00000001);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ design/hgcd_cordic_rot.sv @@
module hgcd_cordic_rot #(
    parameter int STEPS = hgcd_pkg::CORDIC_STEPS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  hgcd_pkg::t_q i_theta,
    input  logic         i_neg,
    output logic         o_valid,
    output hgcd_pkg::t_q o_cos,
    output hgcd_pkg::t_q o_sin
);
    import hgcd_pkg::*;

    t_q   r_x   [STEPS];
    t_q   r_y   [STEPS];
    t_q   r_z   [STEPS];
    logic r_neg [STEPS];
    logic r_vld [STEPS];

    // one micro-rotation per stage
    for (genvar g = 0; g < STEPS; g++) begin : g_stage
        localparam int K = g % 32;
        t_q   x_in, y_in, z_in;
        logic neg_in, vld_in;
        t_q   n_x, n_y, n_z;

        if (g == 0) begin : g_first
            assign x_in   = CORDIC_GAIN_INV;
            assign y_in   = '0;
            assign z_in   = i_theta;
            assign neg_in = i_neg;
            assign vld_in = i_valid;
        end else begin : g_next
            assign x_in   = r_x[g-1];
            assign y_in   = r_y[g-1];
            assign z_in   = r_z[g-1];
            assign neg_in = r_neg[g-1];
            assign vld_in = r_vld[g-1];
        end

        always_comb begin
            t_q xr;
            if (z_in >= 0) begin
                xr  = x_in - (y_in >>> K);
                n_y = y_in + (x_in >>> K);
                n_z = z_in - atan_q30(K);
            end else begin
                xr  = x_in + (y_in >>> K);
                n_y = y_in - (x_in >>> K);
                n_z = z_in + atan_q30(K);
            end
            // cosine sign flip for folded angles on the last stage
            if (g == STEPS - 1 && neg_in) begin
                n_x = -xr;
            end else begin
                n_x = xr;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g]   <= n_x;
                r_y[g]   <= n_y;
                r_z[g]   <= n_z;
                r_neg[g] <= neg_in;
            end
        end
    end

    assign o_valid = r_vld[STEPS-1];
    assign o_cos   = r_x[STEPS-1];
    assign o_sin   = r_y[STEPS-1];

endmodule

@@ design/hgcd_cordic_vec.sv @@
module hgcd_cordic_vec #(
    parameter int STEPS = hgcd_pkg::CORDIC_STEPS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  hgcd_pkg::t_q i_x,
    input  hgcd_pkg::t_q i_y,
    output logic         o_valid,
    output hgcd_pkg::t_q o_angle
);
    import hgcd_pkg::*;

    t_q   r_x   [STEPS];
    t_q   r_y   [STEPS];
    t_q   r_z   [STEPS];
    logic r_vld [STEPS];

    // one vectoring step per stage, driving y toward zero
    for (genvar g = 0; g < STEPS; g++) begin : g_stage
        localparam int K = g % 32;
        t_q   x_in, y_in, z_in;
        logic vld_in;
        t_q   n_x, n_y, n_z;

        if (g == 0) begin : g_first
            assign x_in   = i_x;
            assign y_in   = i_y;
            assign z_in   = '0;
            assign vld_in = i_valid;
        end else begin : g_next
            assign x_in   = r_x[g-1];
            assign y_in   = r_y[g-1];
            assign z_in   = r_z[g-1];
            assign vld_in = r_vld[g-1];
        end

        always_comb begin
            if (y_in >= 0) begin
                n_x = x_in + (y_in >>> K);
                n_y = y_in - (x_in >>> K);
                n_z = z_in + atan_q30(K);
            end else begin
                n_x = x_in - (y_in >>> K);
                n_y = y_in + (x_in >>> K);
                n_z = z_in - atan_q30(K);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g] <= n_x;
                r_y[g] <= n_y;
                r_z[g] <= n_z;
            end
        end
    end

    assign o_valid = r_vld[STEPS-1];
    assign o_angle = r_z[STEPS-1];

endmodule

@@ design/hgcd_sqrt.sv @@
module hgcd_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [30:0] i_value,
    output logic        o_valid,
    output logic [30:0] o_root
);
    import hgcd_pkg::*;

    t_sq  r_n   [SQ_STEPS];
    t_sq  r_r   [SQ_STEPS];
    logic r_vld [SQ_STEPS];

    // one result bit per stage, radicand is value times 2^30
    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_stage
        localparam t_sq BIT = t_sq'(1) << (2 * (SQ_STEPS - 1 - g));
        t_sq  n_in, r_in, trial;
        logic vld_in;
        t_sq  n_n, n_r;

        if (g == 0) begin : g_first
            assign n_in   = t_sq'(i_value) << 30;
            assign r_in   = '0;
            assign vld_in = i_valid;
        end else begin : g_next
            assign n_in   = r_n[g-1];
            assign r_in   = r_r[g-1];
            assign vld_in = r_vld[g-1];
        end

        always_comb begin
            trial = r_in + BIT;
            if (n_in >= trial) begin
                n_n = n_in - trial;
                n_r = (r_in >> 1) + BIT;
            end else begin
                n_n = n_in;
                n_r = r_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[g] <= n_n;
                r_r[g] <= n_r;
            end
        end
    end

    assign o_valid = r_vld[SQ_STEPS-1];
    assign o_root  = r_r[SQ_STEPS-1][30:0];

endmodule

@@ design/haversine_great_circle_distance.sv @@
// Haversine great-circle distance, fully pipelined.
// Input stream: one transaction carries two points (lat/lon in signed degrees,
// 20 fraction bits); output stream: one transaction with the distance in km,
// 8 fraction bits, saturated at the 26-bit maximum.
// Config channel: a write sets the sphere radius (km, 8 fraction bits);
// o_cfg_ready is always high. Write it only while no transaction is in flight.
// Throughput: one point pair per cycle while the skid register is not full.
// The path from input acceptance to o_m_tvalid leads through the two cordic
// pipelines and the 31-stage square root besides the other registered stages.
// Reset clears all valid bits and loads the radius with 6371 km.
// When the receiver stalls, the output register holds its result and a skid
// register takes one more; with the skid register full, o_s_tready drops and
// the whole pipeline freezes, so no transaction is lost or repeated.
module haversine_great_circle_distance #(
    parameter int CORDIC_STEPS = hgcd_pkg::CORDIC_STEPS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // lat_a[27:0], lon_a[56:28], lat_b[84:57], lon_b[113:85], zero pad
    input  logic [119:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // distance_q8[25:0], zero pad
    output logic [31:0]  o_m_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [23:0]  i_cfg_data
);
    import hgcd_pkg::*;

    logic en;

    // radius register
    logic [23:0] r_radius;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 24'd1630976;
        end else if (i_cfg_valid) begin
            r_radius <= i_cfg_data;
        end
    end

    // stage 1: unpack and differences
    logic               r_v1;
    logic signed [28:0] r_dlat;
    logic signed [29:0] r_dlon;
    logic signed [27:0] r_lat_a, r_lat_b;
    logic signed [27:0] in_lat_a, in_lat_b;
    logic signed [28:0] in_lon_a, in_lon_b;

    assign in_lat_a = i_s_tdata[27:0];
    assign in_lon_a = i_s_tdata[56:28];
    assign in_lat_b = i_s_tdata[84:57];
    assign in_lon_b = i_s_tdata[113:85];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dlat  <= {in_lat_b[27], in_lat_b} - {in_lat_a[27], in_lat_a};
            r_dlon  <= {in_lon_b[28], in_lon_b} - {in_lon_a[28], in_lon_a};
            r_lat_a <= in_lat_a;
            r_lat_b <= in_lat_b;
        end
    end

    // stage 2: wrap differences to [-180,180), fold latitudes for cosine
    logic               r_v2;
    logic signed [28:0] r_wlat, r_wlon;
    logic signed [28:0] r_fa, r_fb;
    logic               r_nega, r_negb;
    logic signed [30:0] ext_dlat, ext_dlon, wr_lat, wr_lon;
    logic signed [30:0] abs_a, abs_b, fold_a, fold_b;
    logic               neg_a, neg_b;

    always_comb begin
        ext_dlat = 31'(r_dlat);
        ext_dlon = 31'(r_dlon);
        if (ext_dlat >= DEG180) begin
            wr_lat = ext_dlat - DEG360;
        end else if (ext_dlat < -DEG180) begin
            wr_lat = ext_dlat + DEG360;
        end else begin
            wr_lat = ext_dlat;
        end
        if (ext_dlon >= DEG180) begin
            wr_lon = ext_dlon - DEG360;
        end else if (ext_dlon < -DEG180) begin
            wr_lon = ext_dlon + DEG360;
        end else begin
            wr_lon = ext_dlon;
        end
        abs_a = (r_lat_a < 0) ? -31'(r_lat_a) : 31'(r_lat_a);
        abs_b = (r_lat_b < 0) ? -31'(r_lat_b) : 31'(r_lat_b);
        neg_a = abs_a > DEG90;
        neg_b = abs_b > DEG90;
        fold_a = neg_a ? DEG180 - abs_a : abs_a;
        fold_b = neg_b ? DEG180 - abs_b : abs_b;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wlat <= wr_lat[28:0];
            r_wlon <= wr_lon[28:0];
            r_fa   <= fold_a[28:0];
            r_fb   <= fold_b[28:0];
            r_nega <= neg_a;
            r_negb <= neg_b;
        end
    end

    // stage 3: degree to radian products
    logic  r_v3;
    t_prod r_pm_lat, r_pm_lon, r_pm_a, r_pm_b;
    logic  r_nega3, r_negb3;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pm_lat <= P_W'(r_wlat) * P_W'(DEG2RAD_Q32);
            r_pm_lon <= P_W'(r_wlon) * P_W'(DEG2RAD_Q32);
            r_pm_a   <= P_W'(r_fa) * P_W'(DEG2RAD_Q32);
            r_pm_b   <= P_W'(r_fb) * P_W'(DEG2RAD_Q32);
            r_nega3  <= r_nega;
            r_negb3  <= r_negb;
        end
    end

    // stage 4: round to q30 radians, half angles for the sine terms
    logic  r_v4;
    t_q    r_th_lat, r_th_lon, r_th_a, r_th_b;
    logic  r_nega4, r_negb4;
    t_prod rd_lat, rd_lon, rd_a, rd_b;

    always_comb begin
        rd_lat = (r_pm_lat + (t_prod'(1) <<< (SH_HALF - 1))) >>> SH_HALF;
        rd_lon = (r_pm_lon + (t_prod'(1) <<< (SH_HALF - 1))) >>> SH_HALF;
        rd_a   = (r_pm_a + (t_prod'(1) <<< (SH_FULL - 1))) >>> SH_FULL;
        rd_b   = (r_pm_b + (t_prod'(1) <<< (SH_FULL - 1))) >>> SH_FULL;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_th_lat <= rd_lat[Q_W-1:0];
            r_th_lon <= rd_lon[Q_W-1:0];
            r_th_a   <= rd_a[Q_W-1:0];
            r_th_b   <= rd_b[Q_W-1:0];
            r_nega4  <= r_nega3;
            r_negb4  <= r_negb3;
        end
    end

    // valid bits of the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_s_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // four parallel cordic rotators
    logic rot_vld;
    t_q   sin_lat, sin_lon, cos_a, cos_b;
    t_q   unused_c0, unused_c1, unused_s0, unused_s1;
    logic unused_v0, unused_v1, unused_v2, unused_v3;

    hgcd_cordic_rot #(.STEPS(CORDIC_STEPS)) u_rot_lat (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_v4),
        .i_theta(r_th_lat), .i_neg(1'b0),
        .o_valid(rot_vld), .o_cos(unused_c0), .o_sin(sin_lat)
    );
    hgcd_cordic_rot #(.STEPS(CORDIC_STEPS)) u_rot_lon (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_v4),
        .i_theta(r_th_lon), .i_neg(1'b0),
        .o_valid(unused_v0), .o_cos(unused_c1), .o_sin(sin_lon)
    );
    hgcd_cordic_rot #(.STEPS(CORDIC_STEPS)) u_rot_a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_v4),
        .i_theta(r_th_a), .i_neg(r_nega4),
        .o_valid(unused_v1), .o_cos(cos_a), .o_sin(unused_s0)
    );
    hgcd_cordic_rot #(.STEPS(CORDIC_STEPS)) u_rot_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_v4),
        .i_theta(r_th_b), .i_neg(r_negb4),
        .o_valid(unused_v2), .o_cos(cos_b), .o_sin(unused_s1)
    );

    // m1: squares of the half-angle sines and the cosine product
    logic               r_vm1;
    logic signed [31:0] r_ss_lat, r_ss_lon, r_cc;
    logic signed [31:0] s_lat32, s_lon32, c_a32, c_b32;
    logic signed [63:0] m_lat, m_lon, m_cc;

    always_comb begin
        s_lat32 = sin_lat[31:0];
        s_lon32 = sin_lon[31:0];
        c_a32   = cos_a[31:0];
        c_b32   = cos_b[31:0];
        m_lat   = (64'(s_lat32) * 64'(s_lat32)) >>> 30;
        m_lon   = (64'(s_lon32) * 64'(s_lon32)) >>> 30;
        m_cc    = (64'(c_a32) * 64'(c_b32)) >>> 30;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ss_lat <= m_lat[31:0];
            r_ss_lon <= m_lon[31:0];
            r_cc     <= m_cc[31:0];
        end
    end

    // m2: cosine product times longitude term
    logic               r_vm2;
    logic signed [31:0] r_ss_lat2, r_t;
    logic signed [63:0] m_t;

    assign m_t = (64'(r_cc) * 64'(r_ss_lon)) >>> 30;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ss_lat2 <= r_ss_lat;
            r_t       <= m_t[31:0];
        end
    end

    // m3: haversine term, clamped to [0,1], and its complement
    logic               r_vm3;
    logic [30:0]        r_a, r_b;
    logic signed [32:0] sum_a;
    logic [30:0]        clamp_a;

    always_comb begin
        sum_a = 33'(r_ss_lat2) + 33'(r_t);
        if (sum_a < 0) begin
            clamp_a = '0;
        end else if (sum_a > 33'(Q30_ONE)) begin
            clamp_a = Q30_ONE;
        end else begin
            clamp_a = sum_a[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a <= clamp_a;
            r_b <= Q30_ONE - clamp_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm1 <= 1'b0;
            r_vm2 <= 1'b0;
            r_vm3 <= 1'b0;
        end else if (en) begin
            r_vm1 <= rot_vld;
            r_vm2 <= r_vm1;
            r_vm3 <= r_vm2;
        end
    end

    // square roots of a and 1-a
    logic        sq_vld;
    logic [30:0] root_a, root_b;

    hgcd_sqrt u_sqrt_a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_vm3),
        .i_value(r_a), .o_valid(sq_vld), .o_root(root_a)
    );
    hgcd_sqrt u_sqrt_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_vm3),
        .i_value(r_b), .o_valid(unused_v3), .o_root(root_b)
    );

    // arctangent by cordic vectoring
    logic vec_vld;
    t_q   half_ang;

    hgcd_cordic_vec #(.STEPS(CORDIC_STEPS)) u_vec (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(sq_vld),
        .i_x(Q_W'(root_b)), .i_y(Q_W'(root_a)),
        .o_valid(vec_vld), .o_angle(half_ang)
    );

    // f1: central angle times radius
    logic        r_vf1;
    logic [55:0] r_prod;
    logic [31:0] ang;

    assign ang = (half_ang < 0) ? '0 : {half_ang[30:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod <= 56'(r_radius) * 56'(ang);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf1 <= 1'b0;
        end else if (en) begin
            r_vf1 <= vec_vld;
        end
    end

    // rounding to km q8 and saturation
    logic [56:0]       rnd;
    logic [26:0]       d_full;
    logic [DIST_W-1:0] dist_sat;

    always_comb begin
        rnd      = 57'(r_prod) + (57'(1) << 29);
        d_full   = rnd[56:30];
        dist_sat = d_full[26] ? '1 : d_full[DIST_W-1:0];
    end

    // output register with one skid entry
    logic              r_out_vld, r_skid_vld;
    logic [DIST_W-1:0] r_out, r_skid;
    logic              n_out_vld, n_skid_vld;
    logic [DIST_W-1:0] n_out, n_skid;

    assign en = !r_skid_vld;

    always_comb begin
        n_out_vld  = r_out_vld;
        n_out      = r_out;
        n_skid_vld = r_skid_vld;
        n_skid     = r_skid;
        if (r_out_vld && i_m_tready) begin
            if (r_skid_vld) begin
                n_out      = r_skid;
                n_skid_vld = 1'b0;
            end else begin
                n_out_vld = 1'b0;
            end
        end
        if (en && r_vf1) begin
            if (!n_out_vld) begin
                n_out     = dist_sat;
                n_out_vld = 1'b1;
            end else begin
                n_skid     = dist_sat;
                n_skid_vld = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_s_tready = en;
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = 32'(r_out);

endmodule

@@ design/hgcd_checker.sv @@
module hgcd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata
);

    // a held result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    // a held result keeps its data
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("result changed while stalled");

    // input backpressure only when a result is waiting
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled with empty output");

    // distance never exceeds its field
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[31:26] == 6'd0)
        else $error("distance padding not zero");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind haversine_great_circle_distance hgcd_checker u_hgcd_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .o_s_tready(o_s_tready),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata(o_m_tdata)
);
